>>> src/pac_pkg.sv
// pac_pkg: shared types and constants of the pump alternation controller
// no dependencies; compiled first
`default_nettype none

package pac_pkg;

	// fields of the request and result items
	localparam int unsigned ALARM_FIELDS = 4;
	localparam int unsigned REG_PUMPS    = 8;

	// function codes of a request
	localparam logic FUNC_FORCE = 1'b0;
	localparam logic FUNC_CYCLE = 1'b1;

	// configuration register indexes
	localparam logic [0:0] CFG_FILL_TYPE = 1'b0;
	localparam logic [0:0] CFG_ODD_GROUP = 1'b1;

	// pumps switched on by one critical alarm
	localparam logic [1:0] CRIT_PUMPS = 2'd2;

	// duty group codes as shown on the result
	localparam logic [1:0] GROUP_ONE = 2'd1;
	localparam logic [1:0] GROUP_TWO = 2'd2;

	typedef enum logic [3:0] {
		ALARM_NONE      = 4'd0,
		ALARM_LOW       = 4'd1,
		ALARM_HIGH      = 4'd2,
		ALARM_CRIT_LOW  = 4'd3,
		ALARM_CRIT_HIGH = 4'd4,
		ALARM_PRESSURE  = 4'd5,
		ALARM_FLOW      = 4'd6,
		ALARM_CONTAM    = 4'd7,
		ALARM_OTHER     = 4'd8
	} alarm_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CRIT,
		ST_WAVE,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_FORCE,
		OP_ALT
	} pump_op_kind_t;

	typedef struct packed {
		logic       func;
		logic [2:0] pump_index;
		logic       force_on;
		logic [3:0] sensor_ok_mask;
		logic [3:0] alarm_a;
		logic [3:0] alarm_b;
		logic [3:0] alarm_c;
		logic [3:0] alarm_d;
	} req_t;

	typedef struct packed {
		logic [7:0] pumps_running;
		logic [1:0] active_group;
		logic       maintenance_locked;
		logic       cycle_aborted;
	} rsp_t;

	// broadcast operation to every pump cell
	typedef struct packed {
		pump_op_kind_t kind;
		logic          fill;
		logic          grp_two;
		logic          force_on;
	} pump_op_t;

	// static per-pump configuration bits
	typedef struct packed {
		logic has_reg;
		logic fill;
		logic odd;
	} pump_cfg_t;

	// critical-alarm wave passed from cell to cell
	typedef struct packed {
		logic       valid;
		logic       fill;
		logic [1:0] cnt;
	} wave_t;

endpackage

`default_nettype wire

>>> src/pac_ifs.sv
// pac_ifs: valid/ready channel interfaces for requests and results
// depends on pac_pkg
`default_nettype none

interface pac_req_if;
	logic          valid;
	logic          ready;
	pac_pkg::req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface pac_rsp_if;
	logic          valid;
	logic          ready;
	pac_pkg::rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> src/pac_sensor_cell.sv
// pac_sensor_cell: one stage of the rotating alarm-code ring
// no package dependencies
`default_nettype none

module pac_sensor_cell (
	input  wire logic       clk,
	input  wire logic       load,
	input  wire logic       shift,
	input  wire logic [3:0] load_code,
	input  wire logic [3:0] next_code,
	output logic [3:0]      code
);

	logic [3:0] code_q;

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= load_code;
		end else if (shift) begin
			code_q <= next_code;
		end
	end

	assign code = code_q;

endmodule

`default_nettype wire

>>> src/pac_pump_cell.sv
// pac_pump_cell: one pump's run bit plus its stage of the critical wave
// depends on pac_pkg
`default_nettype none

module pac_pump_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pac_pkg::pump_cfg_t cfg,
	input  wire pac_pkg::pump_op_t  op,
	input  wire logic              force_sel,
	input  wire pac_pkg::wave_t     wave_in,
	output pac_pkg::wave_t          wave_out,
	output logic                   on
);

	logic           on_q;
	logic           on_d;
	logic           is_fill;
	logic           alt_on;
	logic           match;
	logic           take;
	pac_pkg::wave_t wave_s1;
	pac_pkg::wave_t wave_d;

	assign is_fill = cfg.has_reg & cfg.fill;
	assign alt_on  = cfg.has_reg & (op.fill ? cfg.fill : ~cfg.fill)
		& (op.grp_two ? ~cfg.odd : cfg.odd);
	assign match   = (is_fill == wave_in.fill);
	assign take    = match && (wave_in.cnt < pac_pkg::CRIT_PUMPS);

	always_comb begin
		on_d = on_q;
		if (wave_in.valid) begin
			// matching type: first pumps start, opposite type stops
			if (match) begin
				on_d = take ? 1'b1 : on_q;
			end else begin
				on_d = 1'b0;
			end
		end else begin
			unique case (op.kind)
				pac_pkg::OP_ALT:   on_d = alt_on;
				pac_pkg::OP_FORCE: on_d = force_sel ? op.force_on : on_q;
				default:           on_d = on_q;
			endcase
		end
		wave_d.valid = wave_in.valid;
		wave_d.fill  = wave_in.fill;
		wave_d.cnt   = take ? wave_in.cnt + 2'd1 : wave_in.cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q    <= 1'b0;
			wave_s1 <= '0;
		end else begin
			on_q    <= on_d;
			wave_s1 <= wave_d;
		end
	end

	assign wave_out = wave_s1;
	assign on       = on_q;

endmodule

`default_nettype wire

>>> src/pump_alternation_controller_unit.sv
// pump_alternation_controller_unit: top level of the pump alternation controller
// depends on pac_pkg, pac_ifs, pac_sensor_cell and pac_pump_cell
`default_nettype none

// Drives a bank of PUMP_COUNT pumps from requests on cmd and returns one
// result per request on res. A forced command (func 0) switches one pump and
// goes straight to the done state. A control cycle (func 1) is refused at
// once when the maintenance latch is set or a used sensor is down; it then
// also goes straight to the done state. Otherwise the alarm codes of the used
// sensors (at most four) are loaded into a ring of sensor cells and rotated
// past a decoder one sensor a cycle, twice, the second lap pausing while a
// wave is in the row: the first lap handles low/high alternation and the
// maintenance alarms, the second lap the critical alarms. Each critical alarm
// launches a wave down the row of pump cells, one cell a cycle, that carries
// the count of pumps already started. From the done state the result is
// loaded into the output register once that is free. A new request is taken
// as soon as the previous one has left the sequencer, even while its result
// still waits in the output register. Configuration writes land on the next
// clock edge.
module pump_alternation_controller_unit #(
	parameter int unsigned PUMP_COUNT   = 8,
	parameter int unsigned SENSOR_COUNT = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	pac_req_if.sink         cmd,
	pac_rsp_if.source       res,
	input  wire logic       cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [7:0] cfg_wdata
);

	// sensors that actually have alarm fields
	localparam int unsigned NS = (SENSOR_COUNT < pac_pkg::ALARM_FIELDS)
		? SENSOR_COUNT : pac_pkg::ALARM_FIELDS;
	localparam int unsigned SIDX_W = (NS > 1) ? $clog2(NS) : 1;
	localparam logic [SIDX_W-1:0] SIDX_LAST = SIDX_W'(NS - 1);

	// configuration registers
	logic [7:0] fill_type_q;
	logic [7:0] odd_group_q;

	// control state
	pac_pkg::state_t state_q;
	pac_pkg::state_t state_d;
	logic [SIDX_W-1:0] sidx_q;
	logic              duty_q;
	logic              maint_q;
	logic              aborted_q;
	logic              res_valid_q;
	pac_pkg::rsp_t     res_q;

	// sequencer controls
	logic              accept;
	logic              is_cycle;
	logic              all_ok;
	logic              refuse;
	logic              load_ring;
	logic              shift_ring;
	logic              sidx_step;
	logic              set_maint;
	logic              toggle_duty;
	logic              out_load;
	logic              sidx_last;
	pac_pkg::pump_op_t op;
	pac_pkg::wave_t    wave_start;

	// sensor ring and pump row
	logic [3:0]      alarm_in [pac_pkg::ALARM_FIELDS];
	logic [3:0]      ring_code [NS];
	logic [3:0]      head;
	pac_pkg::wave_t  wave [PUMP_COUNT+1];
	logic [PUMP_COUNT-1:0] pump_on;
	logic [PUMP_COUNT-1:0] force_sel;
	logic [7:0]      run8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_type_q <= '0;
			odd_group_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pac_pkg::CFG_FILL_TYPE: fill_type_q <= cfg_wdata;
				pac_pkg::CFG_ODD_GROUP: odd_group_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cmd.ready = (state_q == pac_pkg::ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign is_cycle  = (cmd.payload.func == pac_pkg::FUNC_CYCLE);
	assign all_ok    = &cmd.payload.sensor_ok_mask[NS-1:0];
	assign refuse    = maint_q || !all_ok;
	assign sidx_last = (sidx_q == SIDX_LAST);

	assign alarm_in[0] = cmd.payload.alarm_a;
	assign alarm_in[1] = cmd.payload.alarm_b;
	assign alarm_in[2] = cmd.payload.alarm_c;
	assign alarm_in[3] = cmd.payload.alarm_d;

	// rotating ring of alarm codes, cell 0 is the head
	for (genvar i = 0; i < NS; i++) begin : g_sensor
		pac_sensor_cell u_cell (
			.clk       (clk),
			.load      (load_ring),
			.shift     (shift_ring),
			.load_code (alarm_in[i]),
			.next_code (ring_code[(i + 1) % NS]),
			.code      (ring_code[i])
		);
	end

	assign head = ring_code[0];

	// critical wave enters the row at cell 0
	assign wave[0] = wave_start;

	// row of pump cells; the critical wave enters at cell 0
	for (genvar i = 0; i < PUMP_COUNT; i++) begin : g_pump
		pac_pkg::pump_cfg_t cfg;
		if (i < pac_pkg::REG_PUMPS) begin : g_reg
			assign cfg.has_reg  = 1'b1;
			assign cfg.fill     = fill_type_q[i];
			assign cfg.odd      = odd_group_q[i];
			assign force_sel[i] = (cmd.payload.pump_index == 3'(i));
		end else begin : g_noreg
			// pumps beyond the register bits are drain pumps only a critical wave starts
			assign cfg          = '0;
			assign force_sel[i] = 1'b0;
		end
		pac_pump_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (cfg),
			.op        (op),
			.force_sel (force_sel[i]),
			.wave_in   (wave[i]),
			.wave_out  (wave[i+1]),
			.on        (pump_on[i])
		);
	end

	// result shows the pumps that have register bits
	for (genvar j = 0; j < pac_pkg::REG_PUMPS; j++) begin : g_run
		if (j < PUMP_COUNT) begin : g_on
			assign run8[j] = pump_on[j];
		end else begin : g_off
			assign run8[j] = 1'b0;
		end
	end

	// sequencer: next state and controls
	always_comb begin
		state_d     = state_q;
		load_ring   = 1'b0;
		shift_ring  = 1'b0;
		sidx_step   = 1'b0;
		set_maint   = 1'b0;
		toggle_duty = 1'b0;
		out_load    = 1'b0;
		op          = '{kind: pac_pkg::OP_NONE, fill: 1'b0, grp_two: ~duty_q,
			force_on: cmd.payload.force_on};
		wave_start  = '{valid: 1'b0, fill: 1'b0, cnt: 2'd0};
		unique case (state_q)
			pac_pkg::ST_IDLE: begin
				if (accept) begin
					if (!is_cycle) begin
						op.kind = pac_pkg::OP_FORCE;
						state_d = pac_pkg::ST_DONE;
					end else if (refuse) begin
						state_d = pac_pkg::ST_DONE;
					end else begin
						load_ring = 1'b1;
						state_d   = pac_pkg::ST_SCAN;
					end
				end
			end
			pac_pkg::ST_SCAN: begin
				// first lap: alternation and maintenance alarms
				shift_ring = 1'b1;
				sidx_step  = 1'b1;
				unique case (head)
					pac_pkg::ALARM_LOW: begin
						op.kind     = pac_pkg::OP_ALT;
						op.fill     = 1'b1;
						toggle_duty = 1'b1;
					end
					pac_pkg::ALARM_HIGH: begin
						op.kind     = pac_pkg::OP_ALT;
						op.fill     = 1'b0;
						toggle_duty = 1'b1;
					end
					pac_pkg::ALARM_PRESSURE, pac_pkg::ALARM_FLOW,
					pac_pkg::ALARM_CONTAM: begin
						set_maint = 1'b1;
					end
					default: ;
				endcase
				if (sidx_last) begin
					state_d = pac_pkg::ST_CRIT;
				end
			end
			pac_pkg::ST_CRIT: begin
				// second lap: critical alarms launch a wave
				shift_ring = 1'b1;
				sidx_step  = 1'b1;
				if (head == pac_pkg::ALARM_CRIT_LOW || head == pac_pkg::ALARM_CRIT_HIGH) begin
					wave_start = '{valid: 1'b1, fill: (head == pac_pkg::ALARM_CRIT_LOW),
						cnt: 2'd0};
					state_d = pac_pkg::ST_WAVE;
				end else if (sidx_last) begin
					state_d = pac_pkg::ST_DONE;
				end
			end
			pac_pkg::ST_WAVE: begin
				// wave has left the last cell; index wrapped after last sensor
				if (wave[PUMP_COUNT].valid) begin
					state_d = (sidx_q == '0) ? pac_pkg::ST_DONE : pac_pkg::ST_CRIT;
				end
			end
			pac_pkg::ST_DONE: begin
				if (!res_valid_q || res.ready) begin
					out_load = 1'b1;
					state_d  = pac_pkg::ST_IDLE;
				end
			end
			default: state_d = pac_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pac_pkg::ST_IDLE;
			sidx_q      <= '0;
			duty_q      <= 1'b0;
			maint_q     <= 1'b0;
			aborted_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sidx_step) begin
				sidx_q <= sidx_last ? '0 : sidx_q + SIDX_W'(1);
			end
			if (toggle_duty) begin
				duty_q <= ~duty_q;
			end
			if (set_maint) begin
				maint_q <= 1'b1;
			end
			if (accept) begin
				aborted_q <= is_cycle && refuse;
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result register, payload only
	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q.pumps_running      <= run8;
			res_q.active_group       <= duty_q ? pac_pkg::GROUP_TWO : pac_pkg::GROUP_ONE;
			res_q.maintenance_locked <= maint_q;
			res_q.cycle_aborted      <= aborted_q;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

endmodule

`default_nettype wire

>>> src/pac_checker.sv
// pac_checker: port-level checks of the pump alternation controller
// depends on pump_alternation_controller_unit, attached by bind
`default_nettype none

module pac_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	input  wire logic       cmd_ready,
	input  wire logic       res_valid,
	input  wire logic       res_ready,
	input  wire logic [1:0] active_group,
	input  wire logic       maintenance_locked
);

	logic seen_lock_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_lock_q <= 1'b0;
		end else if (res_valid && res_ready && maintenance_locked) begin
			seen_lock_q <= 1'b1;
		end
	end

	// a stalled result keeps valid, its duty group and its lock bit
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(active_group)
			&& $stable(maintenance_locked))
		else $error("result changed while stalled");

	// one request in work at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("request taken while previous one in work");

	a_group: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> active_group == 2'd1 || active_group == 2'd2)
		else $error("duty group out of range");

	// maintenance latch clears only on reset
	a_lock_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && seen_lock_q |-> maintenance_locked)
		else $error("maintenance latch dropped");

endmodule

bind pump_alternation_controller_unit pac_checker u_pac_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.cmd_valid          (cmd.valid),
	.cmd_ready          (cmd.ready),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.active_group       (res.payload.active_group),
	.maintenance_locked (res.payload.maintenance_locked)
);

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// testbench: checks the pump alternation controller against a cycle-accurate-free
// model of its pump, duty group and maintenance latch state; uses pac_pkg and pac_ifs
// and drives pump_alternation_controller_unit through its request/result channels

module testbench;

	localparam int PUMPS       = 8;
	localparam int SENSORS     = 4;
	localparam int CYCLE_LIMIT = 500000;
	// idle tail after the last result, so this covers any late stray result
	localparam int TAIL_CYCLES = 60;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [0:0] cfg_index;
	logic [7:0] cfg_wdata;

	pac_req_if req_ch ();
	pac_rsp_if rsp_ch ();

	pump_alternation_controller_unit #(
		.PUMP_COUNT  (PUMPS),
		.SENSOR_COUNT(SENSORS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (req_ch),
		.res      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// model state: our own view of the controller after each request
	logic [7:0] fill_mask;
	logic [7:0] odd_mask;
	logic [7:0] pump_bits;
	logic       duty_two;   // 0 when group one is on duty
	logic       maint_set;

	pac_pkg::rsp_t pending_status[$];   // predicted results, oldest first
	int   mismatch_count;
	int   cycle_count;
	bit   idle_en;             // random gaps on both channels
	int   hold_left;           // cycles the result side still refuses

	// ------------------------------------------------------------------
	// clock, watchdog
	// ------------------------------------------------------------------
	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// low/high level alarm: hand duty to the other group and run only the
	// pumps of the wanted type in that group
	function automatic void switch_group(input logic fill);
		logic [7:0] type_bits;
		logic [7:0] group_bits;
		duty_two   = ~duty_two;
		type_bits  = fill ? fill_mask : ~fill_mask;
		group_bits = duty_two ? ~odd_mask : odd_mask;
		pump_bits  = type_bits & group_bits;
	endfunction

	// critical alarm: the first pumps of the wanted type come on, every pump
	// of the other type goes off
	function automatic void start_critical(input logic fill);
		int started;
		started = 0;
		for (int i = 0; i < PUMPS; i++) begin
			if (fill_mask[i] == fill) begin
				if (started < pac_pkg::CRIT_PUMPS) begin
					pump_bits[i] = 1'b1;
					started++;
				end
			end else begin
				pump_bits[i] = 1'b0;
			end
		end
	endfunction

	function automatic pac_pkg::rsp_t next_status(input pac_pkg::req_t r);
		logic [3:0]    codes [SENSORS];
		pac_pkg::rsp_t status;
		codes[0] = r.alarm_a;
		codes[1] = r.alarm_b;
		codes[2] = r.alarm_c;
		codes[3] = r.alarm_d;
		status.cycle_aborted = 1'b0;
		if (r.func == pac_pkg::FUNC_FORCE) begin
			// forced commands ignore the latch and the sensors
			pump_bits[r.pump_index] = r.force_on;
		end else if (maint_set || r.sensor_ok_mask != 4'hF) begin
			status.cycle_aborted = 1'b1;
		end else begin
			// first pass: alternation and maintenance alarms, in sensor order;
			// a latch set here does not stop the rest of the cycle
			foreach (codes[i]) begin
				case (codes[i])
					pac_pkg::ALARM_LOW:  switch_group(1'b1);
					pac_pkg::ALARM_HIGH: switch_group(1'b0);
					pac_pkg::ALARM_PRESSURE, pac_pkg::ALARM_FLOW,
					pac_pkg::ALARM_CONTAM: maint_set = 1'b1;
					default: ;
				endcase
			end
			// second pass: critical alarms override the pump pattern
			foreach (codes[i]) begin
				case (codes[i])
					pac_pkg::ALARM_CRIT_LOW:  start_critical(1'b1);
					pac_pkg::ALARM_CRIT_HIGH: start_critical(1'b0);
					default: ;
				endcase
			end
		end
		status.pumps_running      = pump_bits;
		status.active_group       = duty_two ? pac_pkg::GROUP_TWO : pac_pkg::GROUP_ONE;
		status.maintenance_locked = maint_set;
		return status;
	endfunction

	// ------------------------------------------------------------------
	// result side: ready with random stalls, long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= !(idle_en && $urandom_range(99) < 13);
			end
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// compare every accepted result with the oldest prediction
	always @(posedge clk) begin
		pac_pkg::rsp_t got;
		pac_pkg::rsp_t want;
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got = rsp_ch.payload;
			if (pending_status.size() == 0) begin
				report_mismatch($sformatf("result %h with no request pending", got));
			end else begin
				want = pending_status.pop_front();
				if (got.pumps_running !== want.pumps_running)
					report_mismatch($sformatf("pumps_running got %b want %b",
						got.pumps_running, want.pumps_running));
				if (got.active_group !== want.active_group)
					report_mismatch($sformatf("active_group got %0d want %0d",
						got.active_group, want.active_group));
				if (got.maintenance_locked !== want.maintenance_locked)
					report_mismatch($sformatf("maintenance_locked got %b want %b",
						got.maintenance_locked, want.maintenance_locked));
				if (got.cycle_aborted !== want.cycle_aborted)
					report_mismatch($sformatf("cycle_aborted got %b want %b",
						got.cycle_aborted, want.cycle_aborted));
			end
		end
	end

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------

	// valid stays high after the handshake; the next call either puts a new
	// request on the bus in the same step or drops valid for a gap
	task automatic send_request(input pac_pkg::req_t r);
		while (idle_en && $urandom_range(99) < 13) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= r;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		pending_status = {pending_status, next_status(r)};
	endtask

	// stop offering requests and wait until every result is back
	task automatic wait_all_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_status.size() != 0);
	endtask

	// only called with the block idle
	task automatic write_register(input logic [0:0] index, input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		if (index == pac_pkg::CFG_FILL_TYPE)
			fill_mask = value;
		else
			odd_mask = value;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_pump_masks(input logic [7:0] fill, input logic [7:0] odd);
		wait_all_results();
		write_register(pac_pkg::CFG_FILL_TYPE, fill);
		write_register(pac_pkg::CFG_ODD_GROUP, odd);
	endtask

	function automatic pac_pkg::req_t force_req(input logic [2:0] pump, input logic on);
		pac_pkg::req_t r;
		r                = '0;
		r.func           = pac_pkg::FUNC_FORCE;
		r.pump_index     = pump;
		r.force_on       = on;
		r.sensor_ok_mask = 4'hF;
		return r;
	endfunction

	function automatic pac_pkg::req_t cycle_req(input logic [3:0] ok,
		input pac_pkg::alarm_t a, input pac_pkg::alarm_t b,
		input pac_pkg::alarm_t c, input pac_pkg::alarm_t d);
		pac_pkg::req_t r;
		r                = '0;
		r.func           = pac_pkg::FUNC_CYCLE;
		r.sensor_ok_mask = ok;
		r.alarm_a        = a;
		r.alarm_b        = b;
		r.alarm_c        = c;
		r.alarm_d        = d;
		return r;
	endfunction

	// mostly level and critical alarms; maintenance codes only when the
	// latch may be set, since it never clears again
	function automatic logic [3:0] random_alarm(input bit allow_maint);
		int pick;
		pick = $urandom_range(99);
		if (pick < 30)
			return pac_pkg::ALARM_NONE;
		if (pick < 85)
			return 4'($urandom_range(pac_pkg::ALARM_LOW, pac_pkg::ALARM_CRIT_HIGH));
		if (allow_maint && pick < 92)
			return 4'($urandom_range(pac_pkg::ALARM_PRESSURE, pac_pkg::ALARM_CONTAM));
		return 4'($urandom_range(pac_pkg::ALARM_OTHER, 4'hF));
	endfunction

	function automatic pac_pkg::req_t random_req(input bit allow_maint);
		pac_pkg::req_t r;
		r.func           = ($urandom_range(99) < 30) ? pac_pkg::FUNC_FORCE
			: pac_pkg::FUNC_CYCLE;
		r.pump_index     = 3'($urandom_range(7));
		r.force_on       = 1'($urandom_range(1));
		// a down sensor now and then, so the interlock is hit too
		r.sensor_ok_mask = ($urandom_range(99) < 90) ? 4'hF : 4'($urandom_range(15));
		r.alarm_a        = random_alarm(allow_maint);
		r.alarm_b        = random_alarm(allow_maint);
		r.alarm_c        = random_alarm(allow_maint);
		r.alarm_d        = random_alarm(allow_maint);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset masks: every pump is a group-two drain pump
	task automatic test_forced_commands();
		send_request(force_req(3'd0, 1'b1));
		send_request(force_req(3'd7, 1'b1));
		send_request(force_req(3'd3, 1'b1));
		send_request(force_req(3'd7, 1'b0));
		send_request(force_req(3'd0, 1'b0));
		// quiet cycle leaves everything as it was
		send_request(cycle_req(4'hF, pac_pkg::ALARM_NONE, pac_pkg::ALARM_NONE,
			pac_pkg::ALARM_NONE, pac_pkg::ALARM_NONE));
	endtask

	task automatic test_alternation();
		set_pump_masks(8'h0F, 8'h33);
		send_request(cycle_req(4'hF, pac_pkg::ALARM_LOW, pac_pkg::ALARM_NONE,
			pac_pkg::ALARM_NONE, pac_pkg::ALARM_NONE));
		send_request(cycle_req(4'hF, pac_pkg::ALARM_NONE, pac_pkg::ALARM_NONE,
			pac_pkg::ALARM_NONE, pac_pkg::ALARM_HIGH));
		send_request(cycle_req(4'hF, pac_pkg::ALARM_LOW, pac_pkg::ALARM_HIGH,
			pac_pkg::ALARM_NONE, pac_pkg::ALARM_NONE));
		// unknown codes do nothing
		send_request(cycle_req(4'hF, pac_pkg::ALARM_OTHER, pac_pkg::alarm_t'(4'hF),
			pac_pkg::alarm_t'(4'hC), pac_pkg::ALARM_NONE));
		// any sensor down refuses the whole cycle
		send_request(cycle_req(4'hE, pac_pkg::ALARM_LOW, pac_pkg::ALARM_NONE,
			pac_pkg::ALARM_NONE, pac_pkg::ALARM_NONE));
		send_request(cycle_req(4'h7, pac_pkg::ALARM_HIGH, pac_pkg::ALARM_NONE,
			pac_pkg::ALARM_NONE, pac_pkg::ALARM_NONE));
		send_request(cycle_req(4'h0, pac_pkg::ALARM_LOW, pac_pkg::ALARM_LOW,
			pac_pkg::ALARM_NONE, pac_pkg::ALARM_NONE));
	endtask

	task automatic test_critical();
		// all fill pumps: critical high finds nothing to start
		set_pump_masks(8'hFF, 8'h00);
		send_request(cycle_req(4'hF, pac_pkg::ALARM_CRIT_LOW, pac_pkg::ALARM_NONE,
			pac_pkg::ALARM_NONE, pac_pkg::ALARM_NONE));
		send_request(cycle_req(4'hF, pac_pkg::ALARM_NONE, pac_pkg::ALARM_CRIT_HIGH,
			pac_pkg::ALARM_NONE, pac_pkg::ALARM_NONE));
		// all drain pumps
		set_pump_masks(8'h00, 8'hFF);
		send_request(cycle_req(4'hF, pac_pkg::ALARM_HIGH, pac_pkg::ALARM_NONE,
			pac_pkg::ALARM_NONE, pac_pkg::ALARM_NONE));
		send_request(cycle_req(4'hF, pac_pkg::ALARM_NONE, pac_pkg::ALARM_NONE,
			pac_pkg::ALARM_CRIT_LOW, pac_pkg::ALARM_NONE));
		send_request(cycle_req(4'hF, pac_pkg::ALARM_NONE, pac_pkg::ALARM_NONE,
			pac_pkg::ALARM_CRIT_HIGH, pac_pkg::ALARM_CRIT_HIGH));
		// mixed bank: alternation first, then both critical alarms in order
		set_pump_masks(8'h5A, 8'hC3);
		send_request(cycle_req(4'hF, pac_pkg::ALARM_CRIT_LOW, pac_pkg::ALARM_CRIT_HIGH,
			pac_pkg::ALARM_LOW, pac_pkg::ALARM_NONE));
	endtask

	task automatic run_random(input int count, input bit allow_maint);
		repeat (count) send_request(random_req(allow_maint));
	endtask

	task automatic test_random_traffic();
		set_pump_masks(8'h00, 8'h00);
		run_random(320, 1'b0);
		set_pump_masks(8'hFF, 8'hFF);
		run_random(320, 1'b0);
		// a long stretch with no gaps on either side
		set_pump_masks(8'hA5, 8'h3C);
		idle_en = 1'b0;
		run_random(320, 1'b0);
		idle_en = 1'b1;
		set_pump_masks(8'($urandom_range(255)), 8'($urandom_range(255)));
		run_random(320, 1'b0);
		set_pump_masks(8'($urandom_range(255)), 8'($urandom_range(255)));
		run_random(320, 1'b0);
	endtask

	// result side blocked for a long time while requests keep coming, so the
	// output register and the sequencer fill and cmd.ready drops
	task automatic test_backpressure();
		wait_all_results();
		hold_left = 400;
		run_random(16, 1'b0);
		wait_all_results();
	endtask

	// the latch only clears on reset, so this runs last
	task automatic test_maintenance();
		// rest of the cycle still runs after the pressure alarm
		send_request(cycle_req(4'hF, pac_pkg::ALARM_LOW, pac_pkg::ALARM_PRESSURE,
			pac_pkg::ALARM_CRIT_LOW, pac_pkg::ALARM_NONE));
		send_request(cycle_req(4'hF, pac_pkg::ALARM_FLOW, pac_pkg::ALARM_NONE,
			pac_pkg::ALARM_NONE, pac_pkg::ALARM_NONE));
		send_request(cycle_req(4'hF, pac_pkg::ALARM_NONE, pac_pkg::ALARM_CONTAM,
			pac_pkg::ALARM_NONE, pac_pkg::ALARM_NONE));
		// forced commands still get through
		send_request(force_req(3'd5, 1'b1));
		run_random(300, 1'b1);
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_wdata      = '0;
		req_ch.valid   = 1'b0;
		req_ch.payload = '0;
		fill_mask      = '0;
		odd_mask       = '0;
		pump_bits      = '0;
		duty_two       = 1'b0;
		maint_set      = 1'b0;
		mismatch_count = 0;
		cycle_count    = 0;
		hold_left      = 0;
		idle_en        = 1'b1;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_forced_commands();
		test_alternation();
		test_critical();
		test_random_traffic();
		test_backpressure();
		test_maintenance();

		wait_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

>>> pump_alternation_controller_unit.f
src/pac_pkg.sv
src/pac_ifs.sv
src/pac_sensor_cell.sv
src/pac_pump_cell.sv
src/pump_alternation_controller_unit.sv
src/pac_checker.sv
tb/testbench.sv
